// File: hw/rtl/rxs_pkg.sv
`timescale 1ns / 1ps
package rxs_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int ID_W        = 6;
	localparam int SCORE_W     = 10;
	localparam int ADDR_W      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int CMP_W       = CNT_W + 1;
	localparam int KEY_W       = SCORE_W + 2;

	// floor(sum / 3) == (sum * 2731) >> 13, exact for every sum below 8192
	localparam int MEAN_SHIFT  = 13;
	localparam int MEAN_MUL    = 2731;
	localparam int PROD_W      = KEY_W + MEAN_SHIFT;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] s1;
		logic [SCORE_W-1:0] s2;
		logic [SCORE_W-1:0] s3;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT_START,
		ST_GET_I,
		ST_CMP,
		ST_WB,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic              ram_we;
		logic              wsel_cur;
		logic [ADDR_W-1:0] ram_waddr;
		logic              ram_re;
		logic [ADDR_W-1:0] ram_raddr;
		logic              cur_load;
		logic              out_load;
		logic              out_last;
		logic              drop_set;
		logic              drop_clr;
	} cmd_t;

	typedef struct packed {
		logic swap;
		logic out_free;
	} stat_t;

	function automatic logic [KEY_W-1:0] key_of(input rec_t r);
		key_of = KEY_W'(r.s1) + KEY_W'(r.s2) + KEY_W'(r.s3);
	endfunction

endpackage

// File: hw/rtl/rxs_ram.sv
`timescale 1ns / 1ps
module rxs_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/rxs_dp.sv
`timescale 1ns / 1ps
module rxs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rxs_pkg::cmd_t               cmd,
	output rxs_pkg::stat_t              stat,
	input  logic [rxs_pkg::ID_W-1:0]    record_id,
	input  logic [rxs_pkg::SCORE_W-1:0] score_one,
	input  logic [rxs_pkg::SCORE_W-1:0] score_two,
	input  logic [rxs_pkg::SCORE_W-1:0] score_three,
	output logic                        emit_valid,
	input  logic                        emit_stall,
	output logic [rxs_pkg::ID_W-1:0]    out_id,
	output logic [rxs_pkg::SCORE_W-1:0] out_one,
	output logic [rxs_pkg::SCORE_W-1:0] out_two,
	output logic [rxs_pkg::SCORE_W-1:0] out_three,
	output logic [rxs_pkg::SCORE_W-1:0] mean_score,
	output logic                        overflow_flag,
	output logic                        final_out
);
	import rxs_pkg::*;

	rec_t               in_rec;
	rec_t               wdata;
	rec_t               rd_data;
	rec_t               cur_q;
	rec_t               out_rec_q;
	logic [SCORE_W-1:0] out_mean_q;
	logic               out_ovf_q;
	logic               out_final_q;
	logic               out_valid_q;
	logic               drop_q;
	logic [PROD_W-1:0]  mean_prod;

	assign in_rec = '{id: record_id, s1: score_one, s2: score_two, s3: score_three};
	assign wdata  = cmd.wsel_cur ? cur_q : in_rec;

	rxs_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(MAX_RECORDS)
	) u_store (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(cmd.ram_waddr),
		.wdata(wdata),
		.re   (cmd.ram_re),
		.raddr(cmd.ram_raddr),
		.rdata(rd_data)
	);

	assign mean_prod     = PROD_W'(key_of(rd_data)) * PROD_W'(MEAN_MUL);
	assign stat.swap     = key_of(cur_q) < key_of(rd_data);
	assign stat.out_free = !out_valid_q || !emit_stall;

	// held record of the outer loop
	always_ff @(posedge clk) begin
		if (cmd.cur_load) begin
			cur_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd.drop_set) begin
			drop_q <= 1'b1;
		end else if (cmd.drop_clr) begin
			drop_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!emit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rec_q   <= rd_data;
			out_mean_q  <= mean_prod[MEAN_SHIFT +: SCORE_W];
			out_ovf_q   <= drop_q;
			out_final_q <= cmd.out_last;
		end
	end

	assign emit_valid    = out_valid_q;
	assign out_id        = out_rec_q.id;
	assign out_one       = out_rec_q.s1;
	assign out_two       = out_rec_q.s2;
	assign out_three     = out_rec_q.s3;
	assign mean_score    = out_mean_q;
	assign overflow_flag = out_ovf_q;
	assign final_out     = out_final_q;

endmodule

// File: hw/rtl/rxs_ctrl.sv
`timescale 1ns / 1ps
module rxs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_valid,
	output logic           load_stall,
	input  logic           set_end,
	input  rxs_pkg::stat_t stat,
	output rxs_pkg::cmd_t  cmd
);
	import rxs_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] k_q;
	logic              room;
	logic              more_j;
	logic              more_i;
	logic              multi;
	logic              last_k;

	assign room   = cnt_q < CNT_W'(MAX_RECORDS);
	assign more_j = (CMP_W'(j_q) + CMP_W'(1)) < CMP_W'(cnt_q);
	assign more_i = (CMP_W'(i_q) + CMP_W'(2)) < CMP_W'(cnt_q);
	assign multi  = cnt_q >= CNT_W'(2);
	assign last_k = (CMP_W'(k_q) + CMP_W'(1)) == CMP_W'(cnt_q);

	assign load_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (load_valid && set_end) begin
					state_d = ST_SORT_START;
				end
			end
			ST_SORT_START: begin
				state_d = multi ? ST_GET_I : ST_EMIT_RD;
			end
			ST_GET_I: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!more_j) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				state_d = more_i ? ST_GET_I : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				if (stat.out_free) begin
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				state_d = last_k ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ram_we    = load_valid && room;
				cmd.ram_waddr = cnt_q[ADDR_W-1:0];
				cmd.drop_set  = load_valid && !room;
			end
			ST_SORT_START: begin
				cmd.ram_re    = multi;
				cmd.ram_raddr = '0;
			end
			ST_GET_I: begin
				cmd.cur_load  = 1'b1;
				cmd.ram_re    = 1'b1;
				cmd.ram_raddr = i_q + ADDR_W'(1);
			end
			ST_CMP: begin
				cmd.ram_we    = stat.swap;
				cmd.wsel_cur  = 1'b1;
				cmd.ram_waddr = j_q;
				cmd.cur_load  = stat.swap;
				cmd.ram_re    = more_j;
				cmd.ram_raddr = j_q + ADDR_W'(1);
			end
			ST_WB: begin
				cmd.ram_we    = 1'b1;
				cmd.wsel_cur  = 1'b1;
				cmd.ram_waddr = i_q;
				cmd.ram_re    = more_i;
				cmd.ram_raddr = i_q + ADDR_W'(1);
			end
			ST_EMIT_RD: begin
				cmd.ram_re    = stat.out_free;
				cmd.ram_raddr = k_q;
			end
			ST_EMIT_LD: begin
				cmd.out_load = 1'b1;
				cmd.out_last = last_k;
				cmd.drop_clr = last_k;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (load_valid && room) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SORT_START: begin
					i_q <= '0;
					k_q <= '0;
				end
				ST_GET_I: begin
					j_q <= i_q + ADDR_W'(1);
				end
				ST_CMP: begin
					if (more_j) begin
						j_q <= j_q + ADDR_W'(1);
					end
				end
				ST_WB: begin
					i_q <= i_q + ADDR_W'(1);
					k_q <= '0;
				end
				ST_EMIT_LD: begin
					if (last_k) begin
						cnt_q <= '0;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/record_exchange_sort_by_mean.sv
`timescale 1ns / 1ps
// Channel  | handshake               | word
// ---------+-------------------------+-----------------------------------------------
// load     | load_valid / load_stall | record_id, score_one..three, set_end
// emit     | emit_valid / emit_stall | out_id, out_one..three, mean_score,
//          |                         | overflow_flag, final_out
//
// Flow: a record without set_end is stored while the block is idle. A set then
// runs through the exchange sort, bounded by the single read port and single
// write port of the record store; each emitted word passes a read state,
// which waits while the sink stalls, and a load state.
// Reset: arst_n clears the controller, the record count and the drop mark; the
// store itself is not cleared, since only entries of the current set are read.
// Stalls: load_stall stays high from the set_end word until the last word of
// the set sits in the output register; emit_stall holds the output register.
module record_exchange_sort_by_mean (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load_valid,
	output logic                        load_stall,
	input  logic [rxs_pkg::ID_W-1:0]    record_id,
	input  logic [rxs_pkg::SCORE_W-1:0] score_one,
	input  logic [rxs_pkg::SCORE_W-1:0] score_two,
	input  logic [rxs_pkg::SCORE_W-1:0] score_three,
	input  logic                        set_end,
	output logic                        emit_valid,
	input  logic                        emit_stall,
	output logic [rxs_pkg::ID_W-1:0]    out_id,
	output logic [rxs_pkg::SCORE_W-1:0] out_one,
	output logic [rxs_pkg::SCORE_W-1:0] out_two,
	output logic [rxs_pkg::SCORE_W-1:0] out_three,
	output logic [rxs_pkg::SCORE_W-1:0] mean_score,
	output logic                        overflow_flag,
	output logic                        final_out
);
	import rxs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer: count records in, walk i and j over the store, then walk k out.
	rxs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(load_valid),
		.load_stall(load_stall),
		.set_end   (set_end),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, held record for the outer loop, key compare, mean and output register.
	// The inner loop keeps record i in a register: on a swap write it to slot j and
	// take the record from slot j; at the end of the pass write it back to slot i.
	rxs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.record_id    (record_id),
		.score_one    (score_one),
		.score_two    (score_two),
		.score_three  (score_three),
		.emit_valid   (emit_valid),
		.emit_stall   (emit_stall),
		.out_id       (out_id),
		.out_one      (out_one),
		.out_two      (out_two),
		.out_three    (out_three),
		.mean_score   (mean_score),
		.overflow_flag(overflow_flag),
		.final_out    (final_out)
	);

endmodule

// File: hw/rtl/rxs_checker.sv
`timescale 1ns / 1ps
module rxs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        load_valid,
	input logic                        load_stall,
	input logic                        set_end,
	input logic                        emit_valid,
	input logic                        emit_stall,
	input logic [rxs_pkg::SCORE_W-1:0] out_one,
	input logic [rxs_pkg::SCORE_W-1:0] out_two,
	input logic [rxs_pkg::SCORE_W-1:0] out_three,
	input logic [rxs_pkg::SCORE_W-1:0] mean_score,
	input logic                        final_out
);
	import rxs_pkg::*;

	logic [KEY_W-1:0] sum;
	logic [KEY_W-1:0] mean3;

	assign sum   = KEY_W'(out_one) + KEY_W'(out_two) + KEY_W'(out_three);
	assign mean3 = KEY_W'(mean_score) * KEY_W'(3);

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_stall |=> emit_valid)
		else $error("emit word dropped while stalled");

	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid && !load_stall && set_end |=> load_stall)
		else $error("load taken right after set end");

	a_gap_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_stall && final_out |=> !emit_valid)
		else $error("emit word follows final word without a gap");

	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> (mean3 <= sum) && ((sum - mean3) < KEY_W'(3)))
		else $error("mean does not match scores");

endmodule

bind record_exchange_sort_by_mean rxs_checker u_rxs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.load_valid(load_valid),
	.load_stall(load_stall),
	.set_end   (set_end),
	.emit_valid(emit_valid),
	.emit_stall(emit_stall),
	.out_one   (out_one),
	.out_two   (out_two),
	.out_three (out_three),
	.mean_score(mean_score),
	.final_out (final_out)
);

// File: tb/record_sort_checker.sv
`timescale 1ns / 1ps
module record_sort_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load_valid,
	input  logic                        load_stall,
	input  logic [rxs_pkg::ID_W-1:0]    record_id,
	input  logic [rxs_pkg::SCORE_W-1:0] score_one,
	input  logic [rxs_pkg::SCORE_W-1:0] score_two,
	input  logic [rxs_pkg::SCORE_W-1:0] score_three,
	input  logic                        set_end,
	input  logic                        emit_valid,
	input  logic                        emit_stall,
	input  logic [rxs_pkg::ID_W-1:0]    out_id,
	input  logic [rxs_pkg::SCORE_W-1:0] out_one,
	input  logic [rxs_pkg::SCORE_W-1:0] out_two,
	input  logic [rxs_pkg::SCORE_W-1:0] out_three,
	input  logic [rxs_pkg::SCORE_W-1:0] mean_score,
	input  logic                        overflow_flag,
	input  logic                        final_out,
	output int                          fail_count,
	output int                          words_owed
);
	import rxs_pkg::*;

	typedef struct packed {
		rec_t               rec;
		logic [SCORE_W-1:0] mean;
		logic               dropped;
		logic               last;
	} ranked_word_t;

	rec_t         set_buf [MAX_RECORDS];
	int           set_size    = 0;
	logic         set_dropped = 1'b0;
	ranked_word_t ranked_q [$];
	int           mismatches  = 0;
	int           owed        = 0;

	assign fail_count = mismatches;
	assign words_owed = owed;

	function automatic int score_sum(input rec_t r);
		return int'(r.s1) + int'(r.s2) + int'(r.s3);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
		end
	endtask

	// Exchange sort, descending by sum; equal sums never swap.
	task automatic rank_set();
		rec_t         tmp;
		ranked_word_t w;
		for (int i = 0; i + 1 < set_size; i++) begin
			for (int j = i + 1; j < set_size; j++) begin
				if (score_sum(set_buf[ADDR_W'(i)]) < score_sum(set_buf[ADDR_W'(j)])) begin
					tmp                  = set_buf[ADDR_W'(i)];
					set_buf[ADDR_W'(i)] = set_buf[ADDR_W'(j)];
					set_buf[ADDR_W'(j)] = tmp;
				end
			end
		end
		for (int k = 0; k < set_size; k++) begin
			w.rec     = set_buf[ADDR_W'(k)];
			w.mean    = SCORE_W'(score_sum(set_buf[ADDR_W'(k)]) / 3);
			w.dropped = set_dropped;
			w.last    = (k == set_size - 1);
			ranked_q  = {ranked_q, w};
		end
		set_size    = 0;
		set_dropped = 1'b0;
	endtask

	always @(posedge clk) begin
		ranked_word_t want;
		if (arst_n) begin
			if (emit_valid && !emit_stall) begin
				if (ranked_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word, id %0d", out_id));
				end else begin
					want = ranked_q.pop_front();
					if ($isunknown({out_id, out_one, out_two, out_three, mean_score,
							overflow_flag, final_out})) begin
						report_mismatch("unknown bits in emitted word");
					end
					check_field("out_id", int'(out_id), int'(want.rec.id));
					check_field("out_one", int'(out_one), int'(want.rec.s1));
					check_field("out_two", int'(out_two), int'(want.rec.s2));
					check_field("out_three", int'(out_three), int'(want.rec.s3));
					check_field("mean_score", int'(mean_score), int'(want.mean));
					check_field("overflow_flag", int'(overflow_flag), int'(want.dropped));
					check_field("final_out", int'(final_out), int'(want.last));
				end
			end
			if (load_valid && !load_stall) begin
				if (set_size < MAX_RECORDS) begin
					set_buf[ADDR_W'(set_size)].id = record_id;
					set_buf[ADDR_W'(set_size)].s1 = score_one;
					set_buf[ADDR_W'(set_size)].s2 = score_two;
					set_buf[ADDR_W'(set_size)].s3 = score_three;
					set_size++;
				end else begin
					set_dropped = 1'b1;
				end
				if (set_end) begin
					rank_set();
				end
			end
		end
		owed = ranked_q.size();
	end

endmodule

// File: tb/record_exchange_sort_by_mean_test.sv
`timescale 1ns / 1ps
module record_exchange_sort_by_mean_test;
	import rxs_pkg::*;

	// Worst case is far below this, also with full sets and a stalled sink.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int SCORE_TOP     = 1000;
	localparam int SCORE_FULL    = (1 << SCORE_W) - 1;
	localparam int ID_FULL       = (1 << ID_W) - 1;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               load_valid  = 1'b0;
	logic               load_stall;
	logic [ID_W-1:0]    record_id   = '0;
	logic [SCORE_W-1:0] score_one   = '0;
	logic [SCORE_W-1:0] score_two   = '0;
	logic [SCORE_W-1:0] score_three = '0;
	logic               set_end     = 1'b0;
	logic               emit_valid;
	logic               emit_stall  = 1'b0;
	logic [ID_W-1:0]    out_id;
	logic [SCORE_W-1:0] out_one;
	logic [SCORE_W-1:0] out_two;
	logic [SCORE_W-1:0] out_three;
	logic [SCORE_W-1:0] mean_score;
	logic               overflow_flag;
	logic               final_out;

	int fail_count;
	int words_owed;
	int cycle_count   = 0;
	int words_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	record_exchange_sort_by_mean u_top (.*);

	record_sort_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sink side: stall at random, at the rate of the current phase.
	always @(posedge clk) begin
		emit_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Present one word and hold it until the block takes it. Idle cycles are
	// inserted before the word only, so a presented word never changes.
	task automatic send_word(input logic [ID_W-1:0] id, input logic [SCORE_W-1:0] a,
			input logic [SCORE_W-1:0] b, input logic [SCORE_W-1:0] c, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			load_valid <= 1'b0;
			@(posedge clk);
		end
		load_valid  <= 1'b1;
		record_id   <= id;
		score_one   <= a;
		score_two   <= b;
		score_three <= c;
		set_end     <= last;
		@(posedge clk);
		while (load_stall) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// Mix plain scores with the range ends, values past 1000 that the field
	// still allows, and coarse values that make equal sums common.
	function automatic logic [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return SCORE_W'(SCORE_TOP);
			end
			2: begin
				return SCORE_W'($urandom_range(SCORE_TOP + 1, SCORE_FULL));
			end
			3, 4: begin
				return SCORE_W'(100 * $urandom_range(0, 3));
			end
			default: begin
				return SCORE_W'($urandom_range(0, SCORE_TOP));
			end
		endcase
	endfunction

	// Send one set of random records; the last one carries set_end.
	task automatic send_set(input int size);
		for (int k = 0; k < size; k++) begin
			send_word(ID_W'($urandom_range(0, ID_FULL)), pick_score(), pick_score(),
				pick_score(), k == size - 1);
		end
	endtask

	// Drop valid and hold off until every predicted word has been emitted.
	// Wait for a clock edge first so that a set_end just taken is already predicted.
	task automatic drain();
		load_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) begin
			@(posedge clk);
		end
	endtask

	// One idling setting: open with a set of a fixed size, then random sets,
	// mostly short, with an occasional longer one and an occasional drain.
	task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
			input int lead_size);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target        = words_sent + n_items;
		send_set(lead_size);
		while (words_sent < target) begin
			if ($urandom_range(0, 7) == 0) begin
				send_set($urandom_range(9, 24));
			end else begin
				send_set($urandom_range(1, 8));
			end
			if ($urandom_range(0, 5) == 0) begin
				drain();
			end
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-record sets at both ends of every field.
		send_word(ID_W'(ID_FULL), SCORE_W'(SCORE_FULL), SCORE_W'(SCORE_FULL),
			SCORE_W'(SCORE_FULL), 1'b1);
		send_word('0, '0, '0, '0, 1'b1);
		send_word(ID_W'(21), SCORE_W'(SCORE_TOP), SCORE_W'(SCORE_TOP),
			SCORE_W'(SCORE_TOP), 1'b1);

		// Equal sums split differently: arrival order must survive.
		send_word(ID_W'(1), SCORE_W'(300), SCORE_W'(300), SCORE_W'(300), 1'b0);
		send_word(ID_W'(2), SCORE_W'(900), '0, '0, 1'b0);
		send_word(ID_W'(3), '0, '0, SCORE_W'(900), 1'b1);

		// Ascending sums: every pair swaps.
		send_word(ID_W'(4), '0, '0, '0, 1'b0);
		send_word(ID_W'(5), SCORE_W'(SCORE_TOP), '0, '0, 1'b0);
		send_word(ID_W'(6), SCORE_W'(SCORE_TOP), SCORE_W'(SCORE_TOP), '0, 1'b0);
		send_word(ID_W'(7), SCORE_W'(SCORE_FULL), SCORE_W'(SCORE_FULL), SCORE_W'(SCORE_FULL),
			1'b1);

		// Small sums: mean truncation at 0, 0, 1, 1.
		send_word(ID_W'(42), SCORE_W'(1), '0, '0, 1'b0);
		send_word(ID_W'(43), '0, SCORE_W'(2), '0, 1'b0);
		send_word(ID_W'(44), '0, SCORE_W'(2), SCORE_W'(2), 1'b0);
		send_word(ID_W'(45), SCORE_W'(1), SCORE_W'(2), SCORE_W'(2), 1'b1);
		drain();

		// Slow source and stalling sink; lead with a set whose set_end word
		// overflows the store.
		run_phase(38, 61, 95, MAX_RECORDS + 1);
		// Roles swapped; lead with two dropped records.
		run_phase(61, 38, 95, MAX_RECORDS + 2);
		// Full speed on both sides; lead with a set that just fills the store.
		run_phase(0, 0, 95, MAX_RECORDS);

		// Hold a little longer to catch any stray word.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: record_exchange_sort_by_mean.f
hw/rtl/rxs_pkg.sv
hw/rtl/rxs_ram.sv
hw/rtl/rxs_dp.sv
hw/rtl/rxs_ctrl.sv
hw/rtl/record_exchange_sort_by_mean.sv
hw/rtl/rxs_checker.sv
tb/record_sort_checker.sv
tb/record_exchange_sort_by_mean_test.sv
